// File: sv/bcc_pkg.sv
// Shared types and constants for the character-class classifier.
// No dependencies; compiled first.
`timescale 1ns / 1ps
`default_nettype none

package bcc_pkg;

  // Command codes carried by the cmd field
  typedef enum logic [2:0] {
    CMD_CLASSIFY = 3'd0,
    CMD_NODE_WR  = 3'd1,
    CMD_LUT_WR   = 3'd2,
    CMD_ROOT_WR  = 3'd3,
    CMD_MEMBER   = 3'd4
  } cmd_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LUT,
    ST_ROOT,
    ST_WALK,
    ST_HOLD
  } state_t;

  // One decision node: tested codepoint bit and the two children
  typedef struct packed {
    logic [4:0]  bit_sel;
    logic [11:0] lo;
    logic [11:0] hi;
  } node_t;

  localparam int CP_W        = 21;
  localparam int IDX_W       = 12;
  localparam int CLASS_W     = 8;
  localparam int TABLE_LIMIT = 65536;
  localparam int WALK_LIMIT  = 21;
  localparam int STEP_W      = $clog2(WALK_LIMIT);

  localparam logic [IDX_W-1:0] LEAF_REJECT = 12'd0;
  localparam logic [IDX_W-1:0] LEAF_ACCEPT = 12'd1;

endpackage

`default_nettype wire

// File: sv/bcc_if.sv
// Valid/ready channel interfaces for the command and result streams.
// Depends on nothing but the field widths listed here.
`timescale 1ns / 1ps
`default_nettype none

// Command channel: one command per transfer
interface bcc_cmd_if;
  logic        valid;
  logic        ready;
  logic [2:0]  cmd;
  logic [20:0] codepoint;
  logic [11:0] node_index;
  logic [4:0]  node_bit;
  logic [11:0] low_child;
  logic [11:0] high_child;
  logic [15:0] lut_index;
  logic [7:0]  class_slot;

  modport source (
    output valid, cmd, codepoint, node_index, node_bit,
           low_child, high_child, lut_index, class_slot,
    input  ready
  );

  modport sink (
    input  valid, cmd, codepoint, node_index, node_bit,
           low_child, high_child, lut_index, class_slot,
    output ready
  );
endinterface

// Result channel: one answer per classify or membership command
interface bcc_result_if;
  logic       valid;
  logic       ready;
  logic [7:0] class_id;
  logic       is_member;
  logic       from_table;

  modport source (output valid, class_id, is_member, from_table, input ready);
  modport sink   (input  valid, class_id, is_member, from_table, output ready);
endinterface

`default_nettype wire

// File: sv/bdd_char_class_classifier.sv
// Top level of the character-class classifier: command decode, the three
// stores and the walk sequencer. Depends on bcc_pkg and bcc_if.
`timescale 1ns / 1ps
`default_nettype none

// Classifies codepoints into character classes. Write commands (node, lookup
// entry, class root) leave the sequencer idle. A classify below 65536 is
// answered by one read of the lookup table after the transfer. Higher
// codepoints walk the decision graph of each class root in turn, class 0
// first: a read of the root, then one read per node visited, at most 21 nodes
// per class. A membership test walks a single graph, likewise at most 21
// nodes. The node walk is bounded by the single read port of the node memory,
// one node per cycle. A result that finds the output register still occupied
// waits in the holding copy until the register drains. The result register
// lets a new command be taken while the previous answer waits. minterm_count
// may only be written while idle.
module bdd_char_class_classifier #(
  parameter int NODE_COUNT = 4096,
  parameter int CLASS_MAX  = 256,
  parameter int LUT_SIZE   = 65536
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_wr_en,
  input  wire logic [8:0] cfg_wr_data,
  bcc_cmd_if.sink         cmd_ch,
  bcc_result_if.source    result_ch
);
  import bcc_pkg::*;

  // Store geometry; node and root indices are bounded by the field widths
  localparam int NODE_DEPTH = (NODE_COUNT < 4096) ? NODE_COUNT : 4096;
  localparam int ROOT_DEPTH = (CLASS_MAX < 256) ? CLASS_MAX : 256;
  localparam int NAW        = $clog2(NODE_DEPTH);
  localparam int RAW        = (ROOT_DEPTH > 1) ? $clog2(ROOT_DEPTH) : 1;
  localparam int LAW        = $clog2(LUT_SIZE);

  localparam logic [IDX_W:0]  NODE_LIMIT = (IDX_W + 1)'(NODE_DEPTH);
  localparam logic [8:0]      ROOT_LIMIT = 9'(ROOT_DEPTH);
  localparam logic [16:0]     LUT_LIMIT  = 17'(LUT_SIZE);
  localparam logic [CP_W-1:0] LUT_CP_LIM = CP_W'(LUT_SIZE);
  localparam logic [CP_W-1:0] TABLE_CP   = CP_W'(TABLE_LIMIT);

  // Stores
  node_t              node_mem [NODE_DEPTH];
  logic [CLASS_W-1:0] lut_mem  [LUT_SIZE];
  logic [IDX_W-1:0]   root_mem [ROOT_DEPTH];

  node_t              node_rdata;
  logic [CLASS_W-1:0] lut_rdata;
  logic [IDX_W-1:0]   root_rdata;
  logic [NAW-1:0]     node_raddr;
  logic [RAW-1:0]     root_raddr;

  // Control and context registers
  state_t             state, state_next;
  logic [8:0]         minterm_count;
  logic [CP_W-1:0]    cp_r;
  logic               mode_member;
  logic               lut_ok;
  logic [CLASS_W-1:0] cls_idx;
  logic [STEP_W-1:0]  step_cnt;

  // Result register and its holding copy
  logic               out_valid;
  logic [CLASS_W-1:0] out_class;
  logic               out_member;
  logic               out_table;
  logic [CLASS_W-1:0] hold_class;
  logic               hold_member;
  logic               hold_table;

  // Decision signals
  logic               accept;
  logic               out_free;
  logic               is_high;
  logic [8:0]         cnt_lim;
  logic               more_cls;
  logic [31:0]        cp_ext;
  logic               bit_val;
  logic [IDX_W-1:0]   child;
  logic [IDX_W-1:0]   cand;
  logic               cand_oob;
  logic               at_limit;
  logic               acc;
  logic               rej;
  logic               done;
  logic               lut_go;
  logic               root_go;
  logic               walk_go;
  logic [CLASS_W-1:0] res_class;
  logic               res_member;
  logic               res_table;

  assign accept   = cmd_ch.valid && cmd_ch.ready;
  assign out_free = !out_valid || result_ch.ready;
  assign is_high  = cmd_ch.codepoint >= TABLE_CP;
  assign cnt_lim  = (minterm_count > ROOT_LIMIT) ? ROOT_LIMIT : minterm_count;
  assign more_cls = ({1'b0, cls_idx} + 9'd1) < cnt_lim;

  // Shared node step: select the tested bit and pick the child
  always_comb begin
    cp_ext  = {11'b0, cp_r};
    bit_val = cp_ext[node_rdata.bit_sel];
    child   = bit_val ? node_rdata.hi : node_rdata.lo;
    case (state)
      ST_IDLE: cand = cmd_ch.node_index;
      ST_ROOT: cand = root_rdata;
      default: cand = child;
    endcase
    cand_oob = {1'b0, cand} >= NODE_LIMIT;
    at_limit = (state == ST_WALK) && (step_cnt == STEP_W'(WALK_LIMIT - 1));
    acc      = !cand_oob && (cand == LEAF_ACCEPT);
    rej      = !acc && (cand_oob || (cand == LEAF_REJECT) || at_limit);
  end

  // Sequencer decisions and the result of this cycle
  always_comb begin
    done       = 1'b0;
    lut_go     = 1'b0;
    root_go    = 1'b0;
    walk_go    = 1'b0;
    res_class  = '0;
    res_member = 1'b0;
    res_table  = 1'b0;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          case (cmd_ch.cmd)
            CMD_CLASSIFY: begin
              if (!is_high) begin
                lut_go = 1'b1;
              end else if (cnt_lim == 9'd0) begin
                done = 1'b1;
              end else begin
                root_go = 1'b1;
              end
            end
            CMD_MEMBER: begin
              if (acc || rej) begin
                done       = 1'b1;
                res_member = acc;
              end else begin
                walk_go = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      ST_LUT: begin
        done      = 1'b1;
        res_class = lut_ok ? lut_rdata : '0;
        res_table = 1'b1;
      end
      ST_ROOT, ST_WALK: begin
        if (acc) begin
          done       = 1'b1;
          res_member = mode_member;
          res_class  = mode_member ? '0 : cls_idx;
        end else if (rej) begin
          if (mode_member || !more_cls) begin
            done = 1'b1;
          end else begin
            root_go = 1'b1;
          end
        end else begin
          walk_go = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_HOLD: begin
        state_next = out_free ? ST_IDLE : ST_HOLD;
      end
      ST_IDLE, ST_LUT, ST_ROOT, ST_WALK: begin
        if (done) begin
          state_next = out_free ? ST_IDLE : ST_HOLD;
        end else if (lut_go) begin
          state_next = ST_LUT;
        end else if (root_go) begin
          state_next = ST_ROOT;
        end else if (walk_go) begin
          state_next = ST_WALK;
        end else begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs: handshake and read addresses
  always_comb begin
    cmd_ch.ready = (state == ST_IDLE);
    node_raddr   = cand[NAW-1:0];
    if (state == ST_IDLE) begin
      root_raddr = '0;
    end else begin
      root_raddr = RAW'(cls_idx + 8'd1);
    end
  end

  assign result_ch.valid      = out_valid;
  assign result_ch.class_id   = out_class;
  assign result_ch.is_member  = out_member;
  assign result_ch.from_table = out_table;

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      minterm_count <= '0;
      out_valid     <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_wr_en) begin
        minterm_count <= cfg_wr_data;
      end
      if ((done && out_free) || (state == ST_HOLD && out_free)) begin
        out_valid <= 1'b1;
      end else if (result_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Command context, class and step counters, result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      cp_r        <= cmd_ch.codepoint;
      mode_member <= (cmd_ch.cmd == CMD_MEMBER);
      lut_ok      <= cmd_ch.codepoint < LUT_CP_LIM;
      cls_idx     <= '0;
    end else if (root_go) begin
      cls_idx <= cls_idx + 8'd1;
    end
    if (walk_go) begin
      step_cnt <= (state == ST_WALK) ? step_cnt + STEP_W'(1) : '0;
    end
    if (done && out_free) begin
      out_class  <= res_class;
      out_member <= res_member;
      out_table  <= res_table;
    end else if (done) begin
      hold_class  <= res_class;
      hold_member <= res_member;
      hold_table  <= res_table;
    end else if (state == ST_HOLD && out_free) begin
      out_class  <= hold_class;
      out_member <= hold_member;
      out_table  <= hold_table;
    end
  end

  // Node memory; leaves are never stored and their entries are never used
  always_ff @(posedge clk) begin
    if (accept && cmd_ch.cmd == CMD_NODE_WR && cmd_ch.node_index >= 12'd2 &&
        {1'b0, cmd_ch.node_index} < NODE_LIMIT) begin
      node_mem[cmd_ch.node_index[NAW-1:0]] <= '{bit_sel: cmd_ch.node_bit,
                                                lo:      cmd_ch.low_child,
                                                hi:      cmd_ch.high_child};
    end
    node_rdata <= node_mem[node_raddr];
  end

  // Lookup table for codepoints below 65536
  always_ff @(posedge clk) begin
    if (accept && cmd_ch.cmd == CMD_LUT_WR && {1'b0, cmd_ch.lut_index} < LUT_LIMIT) begin
      lut_mem[cmd_ch.lut_index[LAW-1:0]] <= cmd_ch.class_slot;
    end
    lut_rdata <= lut_mem[cmd_ch.codepoint[LAW-1:0]];
  end

  // Class root memory
  always_ff @(posedge clk) begin
    if (accept && cmd_ch.cmd == CMD_ROOT_WR && {1'b0, cmd_ch.class_slot} < ROOT_LIMIT) begin
      root_mem[cmd_ch.class_slot[RAW-1:0]] <= cmd_ch.node_index;
    end
    root_rdata <= root_mem[root_raddr];
  end

  // Checks
  a_step_bound: assert property (@(posedge clk) disable iff (rst)
    state == ST_WALK |-> step_cnt < STEP_W'(WALK_LIMIT))
    else $error("walk step counter past limit");

  a_root_in_range: assert property (@(posedge clk) disable iff (rst)
    state == ST_ROOT |-> {1'b0, cls_idx} < cnt_lim)
    else $error("class root read beyond class count");

  a_write_one_cycle: assert property (@(posedge clk) disable iff (rst)
    accept && (cmd_ch.cmd == CMD_NODE_WR || cmd_ch.cmd == CMD_LUT_WR ||
               cmd_ch.cmd == CMD_ROOT_WR) |=> state == ST_IDLE)
    else $error("write command did not return to idle");

  a_member_result: assert property (@(posedge clk) disable iff (rst)
    result_ch.valid && result_ch.is_member |->
      result_ch.class_id == '0 && !result_ch.from_table)
    else $error("membership result carries classify fields");

endmodule

`default_nettype wire

// File: dv/bdd_char_class_classifier_checker.sv
// Scoreboard for the character-class classifier. It mirrors the node, lookup
// and class-root stores from observed command transfers and checks each answer.
// Depends on bcc_pkg and the channel interfaces in bcc_if.
`timescale 1ns / 1ps

module bdd_char_class_classifier_checker
  import bcc_pkg::*;
#(
  parameter int NODE_COUNT = 4096,
  parameter int CLASS_MAX  = 256,
  parameter int LUT_SIZE   = 65536
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_wr_en,
  input  logic [8:0] cfg_wr_data,
  bcc_cmd_if         cmd_ch,
  bcc_result_if      result_ch,
  output int         fail_count,
  output int         answers_owed
);

  typedef struct packed {
    logic [CLASS_W-1:0] class_id;
    logic               is_member;
    logic               from_table;
  } answer_t;

  // Mirrored stores; entries are only read after the stimulus wrote them
  node_t              node_mem [NODE_COUNT];
  logic [CLASS_W-1:0] class_lut [LUT_SIZE];
  logic [IDX_W-1:0]   root_of [CLASS_MAX];
  logic [8:0]         class_limit;
  answer_t            owed_q [$];

  // Follow one decision graph; anything still inside after the step budget rejects
  function automatic logic graph_accepts(logic [IDX_W-1:0] start, logic [CP_W-1:0] cp);
    logic [IDX_W-1:0] cur;
    node_t            nd;
    cur = start;
    for (int steps = 0; steps < WALK_LIMIT; steps++) begin
      if (cur >= NODE_COUNT) return 1'b0;
      if (cur == LEAF_REJECT || cur == LEAF_ACCEPT) break;
      nd = node_mem[cur];
      // bits above the codepoint width read as zero
      cur = (nd.bit_sel < CP_W && cp[nd.bit_sel]) ? nd.hi : nd.lo;
    end
    return cur == LEAF_ACCEPT;
  endfunction

  always @(posedge clk) begin : monitor
    answer_t got;
    answer_t want;
    int      tries;
    if (rst) begin
      class_limit = '0;
      fail_count  = 0;
    end else begin
      if (cfg_wr_en) begin
        class_limit = cfg_wr_data;
      end

      // Answer transfer: compare against the oldest prediction
      if (result_ch.valid && result_ch.ready) begin
        got.class_id   = result_ch.class_id;
        got.is_member  = result_ch.is_member;
        got.from_table = result_ch.from_table;
        if (owed_q.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected answer class %0d member %b table %b", $time,
                   got.class_id, got.is_member, got.from_table);
        end else begin
          want = owed_q.pop_front();
          if (got.class_id !== want.class_id || got.is_member !== want.is_member ||
              got.from_table !== want.from_table) begin
            fail_count++;
            $display("%0t: expected class %0d member %b table %b, got class %0d member %b table %b",
                     $time, want.class_id, want.is_member, want.from_table,
                     got.class_id, got.is_member, got.from_table);
          end
        end
      end

      // Command transfer: update the stores or predict the answer
      if (cmd_ch.valid && cmd_ch.ready) begin
        case (cmd_ch.cmd)
          CMD_CLASSIFY: begin
            want = '0;
            if (cmd_ch.codepoint < TABLE_LIMIT) begin
              want.from_table = 1'b1;
              if (cmd_ch.codepoint < LUT_SIZE) want.class_id = class_lut[cmd_ch.codepoint];
            end else begin
              tries = (class_limit > CLASS_MAX) ? CLASS_MAX : class_limit;
              if (tries > 256) tries = 256;
              // first class, lowest number first, whose graph accepts
              for (int i = 0; i < tries; i++) begin
                if (graph_accepts(root_of[i], cmd_ch.codepoint)) begin
                  want.class_id = CLASS_W'(i);
                  break;
                end
              end
            end
            owed_q.push_back(want);
          end
          CMD_NODE_WR: begin
            // leaves are fixed
            if (cmd_ch.node_index >= 2 && cmd_ch.node_index < NODE_COUNT) begin
              node_mem[cmd_ch.node_index] = '{bit_sel: cmd_ch.node_bit,
                                              lo: cmd_ch.low_child,
                                              hi: cmd_ch.high_child};
            end
          end
          CMD_LUT_WR: begin
            if (cmd_ch.lut_index < LUT_SIZE) class_lut[cmd_ch.lut_index] = cmd_ch.class_slot;
          end
          CMD_ROOT_WR: begin
            if (cmd_ch.class_slot < CLASS_MAX) root_of[cmd_ch.class_slot] = cmd_ch.node_index;
          end
          CMD_MEMBER: begin
            want = '0;
            want.is_member = graph_accepts(cmd_ch.node_index, cmd_ch.codepoint);
            owed_q.push_back(want);
          end
          default: begin
            // spare codes: no effect, no answer
          end
        endcase
      end
    end
    answers_owed = owed_q.size();
  end

endmodule

// File: dv/bdd_char_class_classifier_tb.sv
// Testbench top for the character-class classifier: clock, reset, command
// stimulus, answer back-pressure, watchdog and verdict. Checking is done by
// bdd_char_class_classifier_checker; depends on bcc_pkg and bcc_if.
`timescale 1ns / 1ps

module bdd_char_class_classifier_tb;
  import bcc_pkg::*;

  localparam int               NODES           = 4096;
  localparam int               LUT_ENTRIES     = 65536;
  localparam logic [2:0]       CMD_SPARE_FIRST = 3'd5;
  localparam logic [2:0]       CMD_SPARE_MID   = 3'd6;
  localparam logic [2:0]       CMD_SPARE_LAST  = 3'd7;
  localparam int               STALL_LIMIT     = 30000;
  localparam int               CHAIN_BASE      = 4000;
  localparam int               CHAIN_LEN       = 22;
  localparam int               PHASE_ITEMS     = 190;
  localparam logic [CP_W-1:0]  CP_TOP          = 21'h1FFFFF;
  localparam logic [CP_W-1:0]  CP_LAST_UNICODE = 21'h10FFFF;

  typedef struct {
    logic [2:0]         op;
    logic [CP_W-1:0]    cp;
    logic [IDX_W-1:0]   node;
    logic [4:0]         bit_no;
    logic [IDX_W-1:0]   lo;
    logic [IDX_W-1:0]   hi;
    logic [15:0]        lut;
    logic [CLASS_W-1:0] slot;
  } order_t;

  logic       clk;
  logic       rst;
  logic       cfg_wr_en;
  logic [8:0] cfg_wr_data;
  int         fail_count;
  int         answers_owed;
  int         quiet_cycles;
  bit         steady;

  // What has been written so far, so that no walk or lookup hits a blank entry
  bit node_known [NODES];
  int node_pool [$];
  bit lut_known [LUT_ENTRIES];
  int lut_pool [$];

  bcc_cmd_if    cmd_ch ();
  bcc_result_if result_ch ();

  bdd_char_class_classifier uut (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .cmd_ch     (cmd_ch),
    .result_ch  (result_ch)
  );

  bdd_char_class_classifier_checker scoreboard (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .cmd_ch      (cmd_ch),
    .result_ch   (result_ch),
    .fail_count  (fail_count),
    .answers_owed(answers_owed)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Command with every field random; callers set the ones that matter
  function automatic order_t noise_order(logic [2:0] op);
    order_t o;
    o.op     = op;
    o.cp     = CP_W'($urandom);
    o.node   = IDX_W'($urandom);
    o.bit_no = 5'($urandom);
    o.lo     = IDX_W'($urandom);
    o.hi     = IDX_W'($urandom);
    o.lut    = 16'($urandom);
    o.slot   = CLASS_W'($urandom);
    return o;
  endfunction

  // A leaf or an already written node
  function automatic logic [IDX_W-1:0] safe_target();
    int r;
    r = $urandom_range(0, 99);
    if (r < 30 || node_pool.size() == 0) return LEAF_ACCEPT;
    if (r < 50) return LEAF_REJECT;
    return IDX_W'(node_pool[$urandom_range(0, node_pool.size() - 1)]);
  endfunction

  // Node write; children only point at leaves, written nodes or the node itself
  function automatic order_t node_order(int idx, logic [4:0] bit_no);
    order_t o;
    o = noise_order(CMD_NODE_WR);
    o.node   = IDX_W'(idx);
    o.bit_no = bit_no;
    if (idx > 1) begin
      if (!node_known[idx]) begin
        node_known[idx] = 1'b1;
        node_pool.push_back(idx);
      end
      o.lo = safe_target();
      o.hi = safe_target();
    end
    return o;
  endfunction

  function automatic order_t lut_order(int idx, logic [CLASS_W-1:0] slot);
    order_t o;
    o = noise_order(CMD_LUT_WR);
    o.lut  = 16'(idx);
    o.slot = slot;
    if (!lut_known[idx]) begin
      lut_known[idx] = 1'b1;
      lut_pool.push_back(idx);
    end
    return o;
  endfunction

  function automatic order_t root_order(logic [CLASS_W-1:0] slot, logic [IDX_W-1:0] tgt);
    order_t o;
    o = noise_order(CMD_ROOT_WR);
    o.slot = slot;
    o.node = tgt;
    return o;
  endfunction

  function automatic order_t classify_order(logic [CP_W-1:0] cp);
    order_t o;
    o = noise_order(CMD_CLASSIFY);
    o.cp = cp;
    return o;
  endfunction

  function automatic order_t member_order(logic [IDX_W-1:0] tgt, logic [CP_W-1:0] cp);
    order_t o;
    o = noise_order(CMD_MEMBER);
    o.node = tgt;
    o.cp   = cp;
    return o;
  endfunction

  // Random mix of table lookups, graph walks, loader writes and spare codes
  function automatic order_t random_order();
    int r;
    int idx;
    logic [CP_W-1:0] cp;
    r = $urandom_range(0, 99);
    if (r < 28) return classify_order(CP_W'(lut_pool[$urandom_range(0, lut_pool.size() - 1)]));
    if (r < 42) begin
      cp = ($urandom_range(0, 9) == 0) ? (($urandom_range(0, 1) == 0) ? CP_LAST_UNICODE : CP_TOP)
                                       : CP_W'($urandom_range(TABLE_LIMIT, 2097151));
      return classify_order(cp);
    end
    if (r < 56) return member_order(safe_target(), CP_W'($urandom));
    if (r < 76) begin
      idx = $urandom_range(0, 99);
      if (idx < 5) idx = $urandom_range(0, 1);
      else if (idx < 30 && node_pool.size() > 0)
        idx = node_pool[$urandom_range(0, node_pool.size() - 1)];
      else idx = $urandom_range(2, NODES - 1);
      return node_order(idx, ($urandom_range(0, 9) == 0) ? 5'($urandom_range(21, 31))
                                                          : 5'($urandom_range(0, 20)));
    end
    if (r < 88) return lut_order($urandom_range(0, LUT_ENTRIES - 1), CLASS_W'($urandom));
    if (r < 95) return root_order(CLASS_W'($urandom), safe_target());
    return noise_order(3'($urandom_range(CMD_SPARE_FIRST, CMD_SPARE_LAST)));
  endfunction

  // Drive one command after a random gap (none while steady) and hold it until the transfer
  task automatic send_order(order_t o);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 3);
    repeat (gap) begin
      @(negedge clk);
      cmd_ch.valid <= 1'b0;
    end
    @(negedge clk);
    cmd_ch.valid      <= 1'b1;
    cmd_ch.cmd        <= o.op;
    cmd_ch.codepoint  <= o.cp;
    cmd_ch.node_index <= o.node;
    cmd_ch.node_bit   <= o.bit_no;
    cmd_ch.low_child  <= o.lo;
    cmd_ch.high_child <= o.hi;
    cmd_ch.lut_index  <= o.lut;
    cmd_ch.class_slot <= o.slot;
    do @(posedge clk); while (!cmd_ch.ready);
  endtask

  // Stop sending and wait for every predicted answer, then a short margin
  task automatic settle(int extra);
    @(negedge clk);
    cmd_ch.valid <= 1'b0;
    while (answers_owed != 0) @(negedge clk);
    repeat (extra) @(negedge clk);
  endtask

  task automatic write_class_limit(logic [8:0] value);
    settle(8);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Answer side: random stall per answer, none while steady
  initial begin : answer_sink
    int stall;
    result_ch.ready = 1'b0;
    forever begin
      stall = steady ? 0 : $urandom_range(0, 3);
      repeat (stall) begin
        @(negedge clk);
        result_ch.ready <= 1'b0;
      end
      @(negedge clk);
      result_ch.ready <= 1'b1;
      do @(posedge clk); while (!(result_ch.valid && result_ch.ready));
    end
  end

  // Watchdog: too long without any transfer means the block hung
  always @(posedge clk) begin
    if (rst || (cmd_ch.valid && cmd_ch.ready) || (result_ch.valid && result_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("bdd_char_class_classifier_tb NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    order_t     o;
    logic [8:0] limits [6];
    rst               = 1'b1;
    steady            = 1'b0;
    cfg_wr_en         = 1'b0;
    cfg_wr_data       = '0;
    cmd_ch.valid      = 1'b0;
    cmd_ch.cmd        = CMD_CLASSIFY;
    cmd_ch.codepoint  = '0;
    cmd_ch.node_index = '0;
    cmd_ch.node_bit   = '0;
    cmd_ch.low_child  = '0;
    cmd_ch.high_child = '0;
    cmd_ch.lut_index  = '0;
    cmd_ch.class_slot = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    write_class_limit(9'd0);

    // Directed: leaf writes are dropped, bit extremes, bits above 20
    send_order(node_order(0, 5'd31));
    send_order(node_order(1, 5'd0));
    o = node_order(2, 5'd0);
    o.lo = LEAF_REJECT;
    o.hi = LEAF_ACCEPT;
    send_order(o);
    o = node_order(NODES - 1, 5'd20);
    o.lo = LEAF_ACCEPT;
    o.hi = 12'd2;
    send_order(o);
    o = node_order(3, 5'd31);
    o.lo = LEAF_ACCEPT;
    o.hi = LEAF_REJECT;
    send_order(o);
    o = node_order(5, 5'd21);
    o.lo = LEAF_REJECT;
    o.hi = LEAF_ACCEPT;
    send_order(o);
    // self loop: the walk runs out of steps
    o = node_order(6, 5'd7);
    o.lo = 12'd6;
    o.hi = 12'd6;
    send_order(o);
    send_order(member_order(LEAF_REJECT, CP_TOP));
    send_order(member_order(LEAF_ACCEPT, '0));
    send_order(member_order(12'd2, 21'd1));
    send_order(member_order(12'd2, 21'd0));
    send_order(member_order(IDX_W'(NODES - 1), CP_TOP));
    send_order(member_order(12'd3, CP_TOP));
    send_order(member_order(12'd5, CP_TOP));
    send_order(member_order(12'd6, CP_TOP));
    // lookup extremes, then high codepoints with no classes in use
    send_order(lut_order(0, 8'hFF));
    send_order(lut_order(LUT_ENTRIES - 1, 8'h00));
    send_order(classify_order('0));
    send_order(classify_order(21'h00FFFF));
    send_order(classify_order(CP_W'(TABLE_LIMIT)));
    send_order(classify_order(CP_LAST_UNICODE));
    send_order(classify_order(CP_TOP));
    send_order(root_order(8'd0, 12'd5));
    send_order(root_order(8'd255, IDX_W'(NODES - 1)));
    send_order(root_order(8'd1, 12'd2));
    send_order(noise_order(CMD_SPARE_FIRST));
    send_order(noise_order(CMD_SPARE_MID));
    send_order(noise_order(CMD_SPARE_LAST));

    // Chain of 22 inner nodes, written tail first: 21 steps still reach accept
    for (int k = CHAIN_LEN - 1; k >= 0; k--) begin
      o = node_order(CHAIN_BASE + k, 5'($urandom));
      o.lo = (k == CHAIN_LEN - 1) ? LEAF_ACCEPT : IDX_W'(CHAIN_BASE + k + 1);
      o.hi = o.lo;
      send_order(o);
    end
    send_order(member_order(IDX_W'(CHAIN_BASE), CP_W'($urandom)));
    send_order(member_order(IDX_W'(CHAIN_BASE + 1), CP_W'($urandom)));

    // Give every class a root before any class count is raised
    for (int s = 0; s < 256; s++) send_order(root_order(CLASS_W'(s), safe_target()));

    // Random phases over several class counts, extremes included
    limits = '{9'd1, 9'd256, 9'd511, 9'd2, 9'($urandom_range(3, 511)), 9'd0};
    for (int ph = 0; ph < 6; ph++) begin
      write_class_limit(limits[ph]);
      steady = (ph % 2 == 1);
      for (int i = 0; i < PHASE_ITEMS; i++) send_order(random_order());
    end

    settle(30);
    if (fail_count == 0) begin
      $display("bdd_char_class_classifier_tb OK");
    end else begin
      $display("bdd_char_class_classifier_tb NOT OK");
    end
    $finish;
  end

endmodule
